### rtl/asymmetric_rational_saturator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the asymmetric rational saturator core
// Short forms for clocked implication checks with a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_RATIONAL_SATURATOR_CORE_MACROS_SVH
`define ASYMMETRIC_RATIONAL_SATURATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define ARSAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ARSAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/arsat_pkg.sv
// ----------------------------------------------------------------------------
// arsat_pkg
// Shared constants and types of the asymmetric rational saturator core.
// ----------------------------------------------------------------------------
package arsat_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int REG_BITS            = 16;
   localparam int CSR_INDEX_BITS      = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAGE_GAIN     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITIVE_SHAPE = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEGATIVE_SHAPE = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_TRIM    = 4'd3;

   // Reset values: unity gain, shape 1.0, unity trim.
   localparam logic [REG_BITS-1:0] GAIN_RESET  = 16'd256;
   localparam logic [REG_BITS-1:0] SHAPE_RESET = 16'd4096;
   localparam logic [REG_BITS-1:0] TRIM_RESET  = 16'd4096;

   // 0.05 in Q4.12.
   localparam logic [REG_BITS-1:0] SHAPE_FLOOR = 16'd205;

   // Rounding constant for the final Q4.12 trim product.
   localparam logic [REG_BITS-1:0] TRIM_HALF = 16'd2048;

   typedef struct packed {
      logic [REG_BITS-1:0] stage_gain;
      logic [REG_BITS-1:0] positive_shape;
      logic [REG_BITS-1:0] negative_shape;
      logic [REG_BITS-1:0] output_trim;
   } cfg_type;

endpackage

### rtl/asymmetric_rational_saturator_core.sv
// ----------------------------------------------------------------------------
// asymmetric_rational_saturator_core
// Asymmetric rational soft clipper for a stream of signed audio samples.
// ----------------------------------------------------------------------------
// Usage: samples enter on the req_ stream (tdata holds sample_in) and shaped
// samples leave on the rsp_ stream (tdata holds sample_out, tuser the
// saturated flag). Each sample is scaled by the gain, mapped to
// v / (1 + k|v|) with a per-sign shape k, scaled by the trim and clamped.
// The four 16-bit registers are written through the csr_ channel, which is
// always ready; write them only while no item is in flight.
// Throughput is one item per clock while rsp_ is not stalled. An item passes
// front stages A-D, the divider (one quotient bit per pipeline stage), back
// stages E-G and the output register between acceptance and rsp_tvalid.
// Reset clears all valid bits and loads unity gain, shape 1.0 and unity trim.
// When the receiver stalls, the output register holds its item and a skid
// entry catches the next one; req_tready then drops until the stall clears,
// so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module asymmetric_rational_saturator_core #(
   parameter int SAMPLE_BITS = arsat_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [TDATA_BITS-1:0]                req_tdata,   // sample_in
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [TDATA_BITS-1:0]                rsp_tdata,   // sample_out
   output logic                                 rsp_tuser,   // saturated
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [arsat_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [arsat_pkg::REG_BITS-1:0]       csr_data
);
   localparam int DW = SAMPLE_BITS + 32;
   localparam int QB = SAMPLE_BITS + 5;

   arsat_pkg::cfg_type cfg_ff;

   logic                   en;
   logic                   fr_valid, fr_neg;
   logic [DW-1:0]          fr_den, fr_rem;
   logic                   dv_valid, dv_neg;
   logic [QB-1:0]          dv_quo;
   logic                   bk_valid, bk_sat;
   logic [SAMPLE_BITS-1:0] bk_sample;
   logic [SAMPLE_BITS:0]   out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_gain     <= arsat_pkg::GAIN_RESET;
         cfg_ff.positive_shape <= arsat_pkg::SHAPE_RESET;
         cfg_ff.negative_shape <= arsat_pkg::SHAPE_RESET;
         cfg_ff.output_trim    <= arsat_pkg::TRIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            arsat_pkg::CSR_STAGE_GAIN:     cfg_ff.stage_gain     <= csr_data;
            arsat_pkg::CSR_POSITIVE_SHAPE: cfg_ff.positive_shape <= csr_data;
            arsat_pkg::CSR_NEGATIVE_SHAPE: cfg_ff.negative_shape <= csr_data;
            arsat_pkg::CSR_OUTPUT_TRIM:    cfg_ff.output_trim    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = en;

   arsat_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid && req_tready),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .out_valid (fr_valid),
      .out_neg   (fr_neg),
      .out_den   (fr_den),
      .out_rem   (fr_rem)
   );

   arsat_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_neg    (fr_neg),
      .in_den    (fr_den),
      .in_rem    (fr_rem),
      .out_valid (dv_valid),
      .out_neg   (dv_neg),
      .out_quo   (dv_quo)
   );

   arsat_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .in_valid   (dv_valid),
      .in_neg     (dv_neg),
      .in_quo     (dv_quo),
      .out_valid  (bk_valid),
      .out_sample (bk_sample),
      .out_sat    (bk_sat)
   );

   arsat_skid #(.WIDTH(SAMPLE_BITS + 1)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bk_valid),
      .in_data   ({bk_sat, bk_sample}),
      .en        (en),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = TDATA_BITS'(out_data[SAMPLE_BITS-1:0]);
   assign rsp_tuser = out_data[SAMPLE_BITS];

endmodule

### rtl/arsat_front.sv
// ----------------------------------------------------------------------------
// arsat_front
// Magnitude, gain product, shape product and divider operand setup.
// ----------------------------------------------------------------------------
module arsat_front #(
   parameter int SAMPLE_BITS = arsat_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  arsat_pkg::cfg_type        cfg,
   input  logic                      in_valid,
   input  logic [SAMPLE_BITS-1:0]    in_sample,
   output logic                      out_valid,
   output logic                      out_neg,
   output logic [SAMPLE_BITS+31:0]   out_den,
   output logic [SAMPLE_BITS+31:0]   out_rem
);
   localparam int F  = SAMPLE_BITS - 1;
   localparam int VW = SAMPLE_BITS + 16;
   localparam int DW = SAMPLE_BITS + 32;
   localparam logic [DW-1:0] DEN_BIAS = {{(DW-F-21){1'b0}}, 1'b1, {(F+20){1'b0}}};

   logic                   a_valid_ff, a_valid_in;
   logic                   a_neg_ff, a_neg_in;
   logic [SAMPLE_BITS-1:0] a_mag_ff, a_mag_in;

   logic                   b_valid_ff;
   logic                   b_neg_ff, b_neg_in;
   logic [VW-1:0]          b_vmag_ff, b_vmag_in;

   logic                   c_valid_ff;
   logic                   c_neg_ff;
   logic [VW-1:0]          c_vmag_ff;
   logic [DW-1:0]          c_kv_ff, c_kv_in;
   logic [15:0]            shape_sel, shape_k;

   logic                   d_valid_ff;
   logic                   d_neg_ff;
   logic [DW-1:0]          d_den_ff, d_den_in;
   logic [DW-1:0]          d_rem_ff, d_rem_in;

   // Stage A: sign and magnitude. The most negative sample maps to 2^F.
   assign a_valid_in = in_valid;
   assign a_neg_in   = in_sample[F];
   assign a_mag_in   = a_neg_in ? (~in_sample + 1'b1) : in_sample;

   // Stage B: gain product. A zero product always takes the positive branch.
   assign b_vmag_in = {16'b0, a_mag_ff} * {{SAMPLE_BITS{1'b0}}, cfg.stage_gain};
   assign b_neg_in  = a_neg_ff && (cfg.stage_gain != 16'd0);

   // Stage C: floored shape times magnitude.
   assign shape_sel = b_neg_ff ? cfg.negative_shape : cfg.positive_shape;
   assign shape_k   = (shape_sel < arsat_pkg::SHAPE_FLOOR) ? arsat_pkg::SHAPE_FLOOR
                                                            : shape_sel;
   assign c_kv_in   = {{(DW-16){1'b0}}, shape_k} * {{(DW-VW){1'b0}}, b_vmag_ff};

   // Stage D: denominator and the first partial remainder of the quotient.
   assign d_den_in = c_kv_ff + DEN_BIAS;
   assign d_rem_in = {{(DW-VW-7){1'b0}}, c_vmag_ff, 7'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_neg_ff  <= a_neg_in;
         a_mag_ff  <= a_mag_in;
         b_neg_ff  <= b_neg_in;
         b_vmag_ff <= b_vmag_in;
         c_neg_ff  <= b_neg_ff;
         c_vmag_ff <= b_vmag_ff;
         c_kv_ff   <= c_kv_in;
         d_neg_ff  <= c_neg_ff;
         d_den_ff  <= d_den_in;
         d_rem_ff  <= d_rem_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_neg   = d_neg_ff;
   assign out_den   = d_den_ff;
   assign out_rem   = d_rem_ff;

endmodule

### rtl/arsat_divider.sv
// ----------------------------------------------------------------------------
// arsat_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module arsat_divider #(
   parameter int SAMPLE_BITS = arsat_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic                     in_neg,
   input  logic [SAMPLE_BITS+31:0]  in_den,
   input  logic [SAMPLE_BITS+31:0]  in_rem,
   output logic                     out_valid,
   output logic                     out_neg,
   output logic [SAMPLE_BITS+4:0]   out_quo
);
   localparam int DW = SAMPLE_BITS + 32;
   // Five integer bits and one bit below the output LSB for rounding.
   localparam int QB = SAMPLE_BITS + 5;

   logic          vld_ff [QB];
   logic          neg_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [DW-1:0] rem_ff [QB];
   logic [QB-1:0] quo_ff [QB];

   logic          vld_prev [QB];
   logic          neg_prev [QB];
   logic [DW-1:0] den_prev [QB];
   logic [DW-1:0] rem_prev [QB];
   logic [QB-1:0] quo_prev [QB];

   for (genvar i = 0; i < QB; i++) begin : g_step
      logic [DW:0]   rem2;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QB-1:0] quo_in;

      if (i == 0) begin : g_first
         assign vld_prev[i] = in_valid;
         assign neg_prev[i] = in_neg;
         assign den_prev[i] = in_den;
         assign rem_prev[i] = in_rem;
         assign quo_prev[i] = '0;
      end else begin : g_next
         assign vld_prev[i] = vld_ff[i-1];
         assign neg_prev[i] = neg_ff[i-1];
         assign den_prev[i] = den_ff[i-1];
         assign rem_prev[i] = rem_ff[i-1];
         assign quo_prev[i] = quo_ff[i-1];
      end

      always_comb begin
         rem2   = {rem_prev[i], 1'b0};
         diff   = rem2 - {1'b0, den_prev[i]};
         ge     = (rem2 >= {1'b0, den_prev[i]});
         rem_in = ge ? diff[DW-1:0] : rem2[DW-1:0];
         quo_in = {quo_prev[i][QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i] <= neg_prev[i];
            den_ff[i] <= den_prev[i];
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign out_neg   = neg_ff[QB-1];
   assign out_quo   = quo_ff[QB-1];

endmodule

### rtl/arsat_back.sv
// ----------------------------------------------------------------------------
// arsat_back
// Quotient rounding, output trim product, clamp and sign restore.
// ----------------------------------------------------------------------------
module arsat_back #(
   parameter int SAMPLE_BITS = arsat_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  arsat_pkg::cfg_type       cfg,
   input  logic                     in_valid,
   input  logic                     in_neg,
   input  logic [SAMPLE_BITS+4:0]   in_quo,
   output logic                     out_valid,
   output logic [SAMPLE_BITS-1:0]   out_sample,
   output logic                     out_sat
);
   localparam int F  = SAMPLE_BITS - 1;
   localparam int QB = SAMPLE_BITS + 5;
   localparam int PW = QB + 16;
   localparam int ZW = PW - 12;
   localparam logic [ZW-1:0] LIMIT_POS = {{(ZW-F){1'b0}}, {F{1'b1}}};
   localparam logic [ZW-1:0] LIMIT_NEG = {{(ZW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

   logic                   e_valid_ff;
   logic                   e_neg_ff;
   logic [QB-1:0]          e_q_ff, e_q_in;

   logic                   f_valid_ff;
   logic                   f_neg_ff;
   logic [PW-1:0]          f_prod_ff, f_prod_in;

   logic                   g_valid_ff;
   logic [SAMPLE_BITS-1:0] g_sample_ff, g_sample_in;
   logic                   g_sat_ff, g_sat_in;

   logic [PW-1:0]          rounded;
   logic [ZW-1:0]          z_mag, limit, z_clamp;
   logic [SAMPLE_BITS-1:0] mag;

   // Round to nearest, ties away from zero, using the extra quotient bit.
   assign e_q_in = {1'b0, in_quo[QB-1:1]} + {{(QB-1){1'b0}}, in_quo[0]};

   assign f_prod_in = {16'b0, e_q_ff} * {{QB{1'b0}}, cfg.output_trim};

   always_comb begin
      rounded  = f_prod_ff + {{(PW-16){1'b0}}, arsat_pkg::TRIM_HALF};
      z_mag    = rounded[PW-1:12];
      limit    = f_neg_ff ? LIMIT_NEG : LIMIT_POS;
      g_sat_in = (z_mag > limit);
      z_clamp  = g_sat_in ? limit : z_mag;
      mag      = z_clamp[SAMPLE_BITS-1:0];
      g_sample_in = f_neg_ff ? (~mag + 1'b1) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= in_valid;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_neg_ff    <= in_neg;
         e_q_ff      <= e_q_in;
         f_neg_ff    <= e_neg_ff;
         f_prod_ff   <= f_prod_in;
         g_sample_ff <= g_sample_in;
         g_sat_ff    <= g_sat_in;
      end
   end

   assign out_valid  = g_valid_ff;
   assign out_sample = g_sample_ff;
   assign out_sat    = g_sat_ff;

endmodule

### rtl/arsat_skid.sv
// ----------------------------------------------------------------------------
// arsat_skid
// Output register with a skid entry; gives a registered pipeline enable.
// ----------------------------------------------------------------------------
module arsat_skid #(
   parameter int WIDTH = arsat_pkg::SAMPLE_BITS_DEFAULT + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             en,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] skid_data_ff;
   logic             take;
   logic             pop;

   // The pipeline moves only while the skid entry is free, so an item that
   // leaves the last stage always has a place to land.
   assign en   = !skid_valid_ff;
   assign take = en && in_valid;
   assign pop  = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### rtl/arsat_checker.sv
// ----------------------------------------------------------------------------
// arsat_checker
// Port-level checks of the saturator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "asymmetric_rational_saturator_core_macros.svh"

module arsat_checker #(
   parameter int SAMPLE_BITS = arsat_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [TDATA_BITS-1:0] rsp_tdata,
   input logic                  rsp_tuser
);
   localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // A stalled result keeps its value and flag.
   `ARSAT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp item changed while stalled")

   // A clamped result sits exactly on one end of the sample range.
   `ARSAT_ASSERT_IMP(a_sat_rail, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata[SAMPLE_BITS-1:0] == MAX_POS) || (rsp_tdata[SAMPLE_BITS-1:0] == MIN_NEG), "saturated flag without a rail value")

   // Reset empties the pipeline and the output register.
   `ARSAT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

   // Input back-pressure only follows a result that was not taken.
   `ARSAT_ASSERT_IMP(a_ready_cause, clock, reset, !req_tready, $past(rsp_tvalid && !rsp_tready), "req_tready low without an output stall")

endmodule

bind asymmetric_rational_saturator_core arsat_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .TDATA_BITS  (TDATA_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
